>>> rtl/core/ffba_pkg.sv
package ffba_pkg;

	// default table depth
	localparam int TABLE_ENTRIES_DEF = 256;
	// a block is split only when it exceeds the request by more than this
	localparam logic [32:0] SPLIT_SLACK = 33'd32;

	// one heap block in the table
	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] size;
		logic        free;
	} ffba_entry_t;

	typedef enum logic [1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_FREE   = 2'd1,
		ACT_REINIT = 2'd2,
		ACT_NOP    = 2'd3
	} ffba_action_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOFIT   = 2'd1,
		STAT_OUTSIDE = 2'd2,
		STAT_NOBLOCK = 2'd3
	} ffba_status_t;

	typedef enum logic [0:0] {
		REG_HEAP_START = 1'b0,
		REG_HEAP_SIZE  = 1'b1
	} ffba_reg_t;

endpackage

>>> rtl/core/ffba_table.sv
module ffba_table #(
	parameter int DEPTH = ffba_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  ffba_pkg::ffba_entry_t    wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output ffba_pkg::ffba_entry_t    rdata
);
	import ffba_pkg::*;

	ffba_entry_t mem_q [DEPTH];
	ffba_entry_t rdata_q;

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/first_fit_block_allocator.sv
// First-fit heap block allocator with split and coalesce.
// Requests enter on the s_ group: s_tuser carries the action (allocate, free,
// reinitialize), s_tdata the request size and the release address. Each request
// gives one result on the m_ group: block start, status, bytes in use, bytes free.
// Heap base and size are written through the cfg_ port; the user must do so only
// while the block is idle, which the block itself does not enforce. The table of
// blocks lives in a one-write, one-read memory with a registered read; every table
// step is a read state, then an evaluate or write state. Allocate scans entries up
// to the first fit and, when a remainder is inserted, moves the later entries up.
// Free scans for the released block, then runs a coalesce pass over the table.
// Reinitialize and the unused action go straight to the result.
// Only one request is worked on at a time; s_tready is high when idle.
// The result waits in an output register; while the receiver stalls a new
// request can still be taken, and its result waits until the register frees.
// Reset empties the table (count zero), clears bytes in use and both config
// registers; no memory clearing pass is needed.
module first_fit_block_allocator #(
	parameter int TABLE_ENTRIES = ffba_pkg::TABLE_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// config write port
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// request channel
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // request_bytes[31:0], release_address[63:32]
	input  logic [1:0]   s_tuser,   // action[1:0]
	// result channel
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata    // block_start[31:0], status[33:32],
	                                // bytes_in_use[65:34], bytes_free[97:66], zero pad
);
	import ffba_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(TABLE_ENTRIES);

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00000000000001,
		ST_A_RD   = 14'b00000000000010,
		ST_A_EV   = 14'b00000000000100,
		ST_SH_RD  = 14'b00000000001000,
		ST_SH_WR  = 14'b00000000010000,
		ST_REM    = 14'b00000000100000,
		ST_F_RD   = 14'b00000001000000,
		ST_F_EV   = 14'b00000010000000,
		ST_C_RD0  = 14'b00000100000000,
		ST_C_LD   = 14'b00001000000000,
		ST_C_RD   = 14'b00010000000000,
		ST_C_EV   = 14'b00100000000000,
		ST_C_FIN  = 14'b01000000000000,
		ST_DONE   = 14'b10000000000000
	} state_t;

	state_t       state_q;
	logic [CW-1:0] cnt_q, i_q, j_q, w_q;
	logic [31:0]  used_q, hs_q, hz_q;
	logic [31:0]  req_q, rel_q, fa_q, old_q, bs_q;
	ffba_status_t stat_q;
	ffba_entry_t  cur_q;
	logic         m_valid_q;
	logic [103:0] m_data_q;

	logic         t_we;
	logic [IW-1:0] t_waddr, t_raddr;
	ffba_entry_t  t_wdata, rd;

	logic         accept;
	logic         hit, split, match, merge, in_window;
	logic [32:0]  used_add, merge_sum, win_end;
	logic [31:0]  used_sub;
	logic [CW-1:0] ip1, jm1;

	ffba_table #(.DEPTH(TABLE_ENTRIES)) u_table (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (rd)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// shared compare and add terms
	always_comb begin
		ip1       = i_q + CW'(1);
		jm1       = j_q - CW'(1);
		hit       = rd.free && (rd.size >= req_q);
		split     = {1'b0, rd.size} > ({1'b0, req_q} + SPLIT_SLACK);
		match     = (rd.addr == rel_q);
		merge     = cur_q.free && rd.free;
		merge_sum = {1'b0, cur_q.size} + {1'b0, rd.size};
		used_add  = {1'b0, used_q} + {1'b0, req_q};
		used_sub  = (used_q >= rd.size) ? (used_q - rd.size) : 32'd0;
		win_end   = {1'b0, hs_q} + {1'b0, hz_q};
		in_window = (s_tdata[63:32] >= hs_q) && ({1'b0, s_tdata[63:32]} < win_end);
	end

	// table port control
	always_comb begin
		t_we    = 1'b0;
		t_waddr = i_q[IW-1:0];
		t_wdata = rd;
		t_raddr = i_q[IW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				t_waddr = '0;
				t_wdata = '{addr: hs_q, size: hz_q, free: 1'b1};
				t_we    = accept && (s_tuser == ACT_REINIT);
			end
			ST_A_EV: begin
				t_we    = hit;
				t_wdata = '{addr: rd.addr, size: (split ? req_q : rd.size), free: 1'b0};
			end
			ST_SH_RD: t_raddr = jm1[IW-1:0];
			ST_SH_WR: begin
				t_we    = 1'b1;
				t_waddr = j_q[IW-1:0];
			end
			ST_REM: begin
				t_we    = 1'b1;
				t_waddr = ip1[IW-1:0];
				t_wdata = '{addr: fa_q + req_q, size: old_q - req_q, free: 1'b1};
			end
			ST_F_EV: begin
				t_we    = match;
				t_wdata = '{addr: rd.addr, size: rd.size, free: 1'b1};
			end
			ST_C_EV: begin
				t_we    = !merge;
				t_waddr = w_q[IW-1:0];
				t_wdata = cur_q;
			end
			ST_C_FIN: begin
				t_we    = 1'b1;
				t_waddr = w_q[IW-1:0];
				t_wdata = cur_q;
			end
			default: ;
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			used_q    <= '0;
			hs_q      <= '0;
			hz_q      <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HEAP_START: hs_q <= cfg_data;
					REG_HEAP_SIZE:  hz_q <= cfg_data;
					default: ;
				endcase
			end
			if (m_valid_q && m_tready && (state_q != ST_DONE)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q  <= s_tdata[31:0];
						rel_q  <= s_tdata[63:32];
						bs_q   <= '0;
						stat_q <= STAT_OK;
						i_q    <= '0;
						unique case (s_tuser)
							ACT_ALLOC: state_q <= ST_A_RD;
							ACT_FREE: begin
								if (in_window) begin
									state_q <= ST_F_RD;
								end else begin
									stat_q  <= STAT_OUTSIDE;
									state_q <= ST_DONE;
								end
							end
							ACT_REINIT: begin
								cnt_q   <= CW'(1);
								used_q  <= '0;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				// first-fit scan
				ST_A_RD: begin
					if (i_q < cnt_q) begin
						state_q <= ST_A_EV;
					end else begin
						stat_q  <= STAT_NOFIT;
						state_q <= ST_DONE;
					end
				end
				ST_A_EV: begin
					if (hit) begin
						bs_q   <= rd.addr;
						fa_q   <= rd.addr;
						old_q  <= rd.size;
						used_q <= used_add[32] ? 32'hFFFF_FFFF : used_add[31:0];
						if (split && (cnt_q < CNT_MAX)) begin
							j_q     <= cnt_q;
							state_q <= ST_SH_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						i_q     <= ip1;
						state_q <= ST_A_RD;
					end
				end
				// move entries up to open a slot after the split block
				ST_SH_RD: begin
					if (j_q > ip1) begin
						state_q <= ST_SH_WR;
					end else begin
						state_q <= ST_REM;
					end
				end
				ST_SH_WR: begin
					j_q     <= jm1;
					state_q <= ST_SH_RD;
				end
				ST_REM: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= ST_DONE;
				end
				// search for the released block
				ST_F_RD: begin
					if (i_q < cnt_q) begin
						state_q <= ST_F_EV;
					end else begin
						stat_q  <= STAT_NOBLOCK;
						state_q <= ST_DONE;
					end
				end
				ST_F_EV: begin
					if (match) begin
						used_q  <= used_sub;
						i_q     <= '0;
						state_q <= ST_C_RD0;
					end else begin
						i_q     <= ip1;
						state_q <= ST_F_RD;
					end
				end
				// coalesce pass, compacting the table in place
				ST_C_RD0: state_q <= ST_C_LD;
				ST_C_LD: begin
					cur_q   <= rd;
					i_q     <= CW'(1);
					w_q     <= '0;
					state_q <= ST_C_RD;
				end
				ST_C_RD: begin
					if (i_q < cnt_q) begin
						state_q <= ST_C_EV;
					end else begin
						state_q <= ST_C_FIN;
					end
				end
				ST_C_EV: begin
					if (merge) begin
						cur_q.size <= merge_sum[32] ? 32'hFFFF_FFFF : merge_sum[31:0];
					end else begin
						cur_q <= rd;
						w_q   <= w_q + CW'(1);
					end
					i_q     <= ip1;
					state_q <= ST_C_RD;
				end
				ST_C_FIN: begin
					cnt_q   <= w_q + CW'(1);
					state_q <= ST_DONE;
				end
				// hand the result to the output register
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {6'd0,
							((hz_q >= used_q) ? (hz_q - used_q) : 32'd0),
							used_q, stat_q, bs_q};
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
